### sv/jgef_pkg.sv
// jgef_pkg: widths, register codes, flag positions and item types
// shared by the joystick gesture event filter; no dependencies
package jgef_pkg;

  // field widths
  localparam int RAW_W      = 12;
  localparam int POS_W      = 8;
  localparam int FLAG_W     = 5;
  localparam int TIME_W     = 32;
  localparam int SEQ_W      = 32;
  localparam int MS_W       = 16;
  localparam int THR_W      = 8;
  localparam int TALLY_W    = 8;

  // axis scaling datapath
  localparam int CTR_W      = 18;
  localparam int MAG_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int RECIP_W    = 23;
  localparam int QEST_W     = 7;
  localparam int M100_W     = 23;
  localparam int SCALE_MAX  = 100;
  localparam int QEST_SAT   = 101;
  localparam int AXIS_LAT   = 4;

  // decoupling queue
  localparam int Q_DEPTH    = 8;
  localparam int Q_PTR_W    = 3;
  localparam int Q_CNT_W    = 4;
  localparam int CREDIT_W   = 5;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS    = 8'd0,
    REG_DOUBLE_WINDOW = 8'd1,
    REG_CHANGE_THR    = 8'd2,
    REG_INVERT_Y      = 8'd3
  } cfg_reg_t;

  localparam logic [MS_W-1:0]  LONG_PRESS_RST    = 16'd700;
  localparam logic [MS_W-1:0]  DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [THR_W-1:0] CHANGE_THR_RST    = 8'd2;
  localparam logic             INVERT_Y_RST      = 1'b1;

  // button flag bit positions
  localparam int FLAG_PRESS  = 0;
  localparam int FLAG_DOUBLE = 1;
  localparam int FLAG_LONG   = 2;
  localparam int FLAG_HOME   = 3;
  localparam int FLAG_BACK   = 4;

  localparam logic [TALLY_W-1:0] TALLY_MAX        = 8'd255;
  localparam logic [TALLY_W-1:0] TALLY_FIRST      = 8'd1;
  localparam logic [TALLY_W-1:0] DOUBLE_MIN_TALLY = 8'd2;

  // classified item between front and back
  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic                    stick;
    logic                    home;
    logic                    back;
    logic [TIME_W-1:0]       now_ms;
  } item_t;

  // settings used by the back end
  typedef struct packed {
    logic [MS_W-1:0]  long_press_ms;
    logic [MS_W-1:0]  double_press_window_ms;
    logic [THR_W-1:0] change_threshold;
  } back_cfg_t;

endpackage

### sv/jgef_if.sv
// jgef_if: valid/ready channel interfaces for samples, events and
// configuration writes; depends on jgef_pkg

// sample channel
interface jgef_in_if import jgef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_x;
  logic [RAW_W-1:0]  raw_y;
  logic              stick_pressed;
  logic              home_btn;
  logic              back_btn;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, raw_x, raw_y, stick_pressed, home_btn,
                  back_btn, now_ms, input ready);
  modport sink (input valid, raw_x, raw_y, stick_pressed, home_btn,
                back_btn, now_ms, output ready);
endinterface

// event channel
interface jgef_out_if import jgef_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic [FLAG_W-1:0]       button_flags;
  logic [SEQ_W-1:0]        sequence_res;

  modport source (output valid, x_pos, y_pos, button_flags, sequence_res,
                  input ready);
  modport sink (input valid, x_pos, y_pos, button_flags, sequence_res,
                output ready);
endinterface

// configuration write channel
interface jgef_cfg_if import jgef_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/jgef_axis.sv
// jgef_axis: four-stage pipeline that centres one axis sample, removes
// the deadzone and scales to -100..100; depends on jgef_pkg
module jgef_axis import jgef_pkg::*; #(
  parameter int ADC_CENTER = 2048,
  parameter int DEADZONE   = 164
) (
  input  logic                    clk,
  input  logic [RAW_W-1:0]        raw,
  input  logic                    inv,
  output logic signed [POS_W-1:0] pos
);

  localparam int     SPAN   = ADC_CENTER - DEADZONE;
  localparam bit     DEGEN  = (SPAN <= 0);
  localparam int     SPAN_C = DEGEN ? 1 : SPAN;
  localparam longint RECIP  = (longint'(SCALE_MAX) << FRAC_W) / SPAN_C;
  localparam int     PROD_W = MAG_W + RECIP_W;

  localparam logic [RECIP_W-1:0]       RECIP_V  = RECIP_W'(RECIP);
  localparam logic [MAG_W-1:0]         SPAN_V   = MAG_W'(SPAN_C);
  localparam logic [MAG_W-1:0]         DZ_V     = MAG_W'(DEADZONE);
  localparam logic signed [CTR_W-1:0]  CENTER_V = CTR_W'(ADC_CENTER);
  localparam logic [M100_W-1:0]        HUNDRED  = M100_W'(SCALE_MAX);
  localparam logic [QEST_W-1:0]        QSAT_V   = QEST_W'(QEST_SAT);
  localparam logic [POS_W-1:0]         QMAX_V   = POS_W'(SCALE_MAX);

  logic signed [CTR_W-1:0] ctr;
  logic signed [CTR_W-1:0] ctr_abs;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        magd;

  logic                    zero1, neg1;
  logic [MAG_W-1:0]        magd1;

  logic [PROD_W-1:0]       prod;
  logic [PROD_W-FRAC_W-1:0] qraw;
  logic                    zero2, neg2, nz2;
  logic [QEST_W-1:0]       qest2;
  logic [M100_W-1:0]       m100_2;

  logic                    zero3, neg3, nz3;
  logic [QEST_W-1:0]       qest3;
  logic [M100_W-1:0]       m100_3;
  logic [M100_W-1:0]       back3;

  logic [M100_W-1:0]       rem;
  logic [POS_W-1:0]        qfix;
  logic [POS_W-1:0]        qlim;

  // centre, magnitude and deadzone removal
  always_comb begin
    ctr     = $signed({{(CTR_W-RAW_W){1'b0}}, raw}) - CENTER_V;
    ctr_abs = ctr[CTR_W-1] ? -ctr : ctr;
    mag     = ctr_abs[MAG_W-1:0];
    magd    = mag - DZ_V;
  end

  // stage 1
  always_ff @(posedge clk) begin
    zero1 <= (mag < DZ_V);
    neg1  <= ctr[CTR_W-1];
    magd1 <= magd;
  end

  // stage 2: reciprocal estimate of magd*100/span, saturated above 101
  always_comb begin
    prod = {{RECIP_W{1'b0}}, magd1} * {{MAG_W{1'b0}}, RECIP_V};
    qraw = prod[PROD_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    zero2  <= zero1;
    neg2   <= neg1;
    nz2    <= (magd1 != '0);
    qest2  <= (qraw > (PROD_W-FRAC_W)'(QEST_SAT)) ? QSAT_V : qraw[QEST_W-1:0];
    m100_2 <= {{(M100_W-MAG_W){1'b0}}, magd1} * HUNDRED;
  end

  // stage 3: estimate times span for the remainder check
  always_ff @(posedge clk) begin
    zero3  <= zero2;
    neg3   <= neg2;
    nz3    <= nz2;
    qest3  <= qest2;
    m100_3 <= m100_2;
    back3  <= {{(M100_W-QEST_W){1'b0}}, qest2} * {{(M100_W-MAG_W){1'b0}}, SPAN_V};
  end

  // stage 4: correct by one, clamp, apply sign and inversion
  always_comb begin
    rem  = m100_3 - back3;
    qfix = {1'b0, qest3} + POS_W'(rem >= {{(M100_W-MAG_W){1'b0}}, SPAN_V});
    if (DEGEN) begin
      qlim = nz3 ? QMAX_V : '0;
    end else begin
      qlim = (qfix > QMAX_V) ? QMAX_V : qfix;
    end
  end

  always_ff @(posedge clk) begin
    if (zero3) begin
      pos <= '0;
    end else if (neg3 ^ inv) begin
      pos <= -$signed(qlim);
    end else begin
      pos <= $signed(qlim);
    end
  end

endmodule

### sv/jgef_front.sv
// jgef_front: accepts sample items, scales both axes and hands classified
// items to the queue with credit flow control; depends on jgef_pkg,
// jgef_if and jgef_axis
module jgef_front import jgef_pkg::*; #(
  parameter int ADC_CENTER = 2048,
  parameter int DEADZONE   = 164
) (
  input  logic               clk,
  input  logic               rst,
  jgef_in_if.sink            samp,
  input  logic               invert_y,
  input  logic [Q_CNT_W-1:0] q_count,
  output logic               push,
  output item_t              push_item
);

  typedef struct packed {
    logic              stick;
    logic              home;
    logic              back;
    logic [TIME_W-1:0] now_ms;
  } side_t;

  logic [AXIS_LAT-1:0]     vld;
  side_t                   side [AXIS_LAT];
  logic [CREDIT_W-1:0]     credit;
  logic                    accept;
  logic signed [POS_W-1:0] x_pos, y_pos;

  // room in the queue for everything already in flight
  assign credit = {{(CREDIT_W-Q_CNT_W){1'b0}}, q_count} + CREDIT_W'($countones(vld));
  assign samp.ready = (credit < CREDIT_W'(Q_DEPTH));
  assign accept = samp.valid && samp.ready;

  // item valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[AXIS_LAT-2:0], accept};
    end
  end

  // buttons and time ride alongside the axis pipeline
  always_ff @(posedge clk) begin
    side[0] <= '{stick: samp.stick_pressed, home: samp.home_btn,
                 back: samp.back_btn, now_ms: samp.now_ms};
    for (int i = 1; i < AXIS_LAT; i++) begin
      side[i] <= side[i-1];
    end
  end

  jgef_axis #(.ADC_CENTER(ADC_CENTER), .DEADZONE(DEADZONE)) u_axis_x (
    .clk (clk),
    .raw (samp.raw_x),
    .inv (1'b0),
    .pos (x_pos)
  );

  jgef_axis #(.ADC_CENTER(ADC_CENTER), .DEADZONE(DEADZONE)) u_axis_y (
    .clk (clk),
    .raw (samp.raw_y),
    .inv (invert_y),
    .pos (y_pos)
  );

  // hand-off to the queue
  assign push = vld[AXIS_LAT-1];
  always_comb begin
    push_item.x_pos  = x_pos;
    push_item.y_pos  = y_pos;
    push_item.stick  = side[AXIS_LAT-1].stick;
    push_item.home   = side[AXIS_LAT-1].home;
    push_item.back   = side[AXIS_LAT-1].back;
    push_item.now_ms = side[AXIS_LAT-1].now_ms;
  end

endmodule

### sv/jgef_queue.sv
// jgef_queue: short register queue of classified items between front
// and back; depends on jgef_pkg
module jgef_queue import jgef_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  item_t              push_item,
  input  logic               pop,
  output item_t              head,
  output logic [Q_CNT_W-1:0] count
);

  item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head = slots[rd_ptr];

endmodule

### sv/jgef_back.sv
// jgef_back: button gesture state, change detection and the event output
// register; depends on jgef_pkg and jgef_if
module jgef_back import jgef_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  back_cfg_t cfg,
  input  logic      q_valid,
  input  item_t     head,
  output logic      pop,
  jgef_out_if.source evt
);

  logic                    was_pressed;
  logic [TIME_W-1:0]       press_start_time;
  logic                    long_fired;
  logic [TALLY_W-1:0]      press_tally;
  logic [TIME_W-1:0]       previous_press_time;
  logic signed [POS_W-1:0] sent_x, sent_y;
  logic [FLAG_W-1:0]       sent_buttons;
  logic [SEQ_W-1:0]        event_count;

  logic                    out_valid;
  logic signed [POS_W-1:0] out_x, out_y;
  logic [FLAG_W-1:0]       out_flags;
  logic [SEQ_W-1:0]        out_seq;

  logic                    rising, in_window, long_hit, dbl_hit, changed;
  logic [TIME_W-1:0]       gap, held;
  logic [TALLY_W-1:0]      tally_upd;
  logic [FLAG_W-1:0]       flags;
  logic signed [POS_W:0]   dx, dy;
  logic [POS_W:0]          adx, ady;

  // take the next item when the output register is free or draining
  assign pop = q_valid && (!out_valid || evt.ready);

  // gesture flags and change test
  always_comb begin
    rising    = head.stick && !was_pressed;
    gap       = head.now_ms - previous_press_time;
    held      = head.now_ms - press_start_time;
    in_window = gap < {{(TIME_W-MS_W){1'b0}}, cfg.double_press_window_ms};
    if (!in_window) begin
      tally_upd = TALLY_FIRST;
    end else if (press_tally != TALLY_MAX) begin
      tally_upd = press_tally + 1'b1;
    end else begin
      tally_upd = press_tally;
    end
    // a fresh press has zero hold time, so it never fires long
    long_hit = head.stick && !rising && !long_fired &&
               (held > {{(TIME_W-MS_W){1'b0}}, cfg.long_press_ms});
    dbl_hit  = !head.stick && was_pressed && (press_tally >= DOUBLE_MIN_TALLY);

    flags              = '0;
    flags[FLAG_PRESS]  = head.stick;
    flags[FLAG_DOUBLE] = dbl_hit;
    flags[FLAG_LONG]   = long_hit;
    flags[FLAG_HOME]   = head.home;
    flags[FLAG_BACK]   = head.back;

    dx  = {head.x_pos[POS_W-1], head.x_pos} - {sent_x[POS_W-1], sent_x};
    dy  = {head.y_pos[POS_W-1], head.y_pos} - {sent_y[POS_W-1], sent_y};
    adx = dx[POS_W] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[POS_W] ? $unsigned(-dy) : $unsigned(dy);
    changed = (adx > {1'b0, cfg.change_threshold}) ||
              (ady > {1'b0, cfg.change_threshold}) ||
              (flags != sent_buttons);
  end

  // state update and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed         <= 1'b0;
      press_start_time    <= '0;
      long_fired          <= 1'b0;
      press_tally         <= '0;
      previous_press_time <= '0;
      sent_x              <= '0;
      sent_y              <= '0;
      sent_buttons        <= '0;
      event_count         <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (pop && changed) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        was_pressed <= head.stick;
        if (rising) begin
          press_start_time    <= head.now_ms;
          previous_press_time <= head.now_ms;
          press_tally         <= tally_upd;
          long_fired          <= 1'b0;
        end else if (long_hit) begin
          long_fired <= 1'b1;
        end
        if (changed) begin
          event_count  <= event_count + 1'b1;
          sent_x       <= head.x_pos;
          sent_y       <= head.y_pos;
          sent_buttons <= flags;
        end
      end
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    if (pop && changed) begin
      out_x     <= head.x_pos;
      out_y     <= head.y_pos;
      out_flags <= flags;
      out_seq   <= event_count + 1'b1;
    end
  end

  assign evt.valid        = out_valid;
  assign evt.x_pos        = out_x;
  assign evt.y_pos        = out_y;
  assign evt.button_flags = out_flags;
  assign evt.sequence_res = out_seq;

endmodule

### sv/joystick_gesture_event_filter.sv
// joystick_gesture_event_filter: top level with configuration registers,
// front end, item queue and back end; depends on jgef_pkg, jgef_if,
// jgef_front, jgef_queue and jgef_back
//
//   channel  | role   | carries
//   ---------+--------+-------------------------------------------------
//   samp     | sink   | raw_x, raw_y, stick/home/back levels, now_ms
//   evt      | source | x_pos, y_pos, button_flags, sequence_res
//   cfg      | sink   | index, data (always ready)
//
// one sample item per cycle while samp.ready is high; each event is
// registered through the four-stage axis scaling pipeline, one queue
// slot and the output register.
// reset is synchronous and clears control state and restores the register
// defaults. samp.ready drops while the queue and the items in flight fill
// all eight queue slots; the back end only waits on a held event.
module joystick_gesture_event_filter import jgef_pkg::*; #(
  parameter int ADC_CENTER = 2048,
  parameter int DEADZONE   = 164
) (
  input  logic       clk,
  input  logic       rst,
  jgef_in_if.sink    samp,
  jgef_out_if.source evt,
  jgef_cfg_if.sink   cfg
);

  back_cfg_t          back_cfg;
  logic               invert_y;
  logic               push, pop;
  item_t              push_item, head;
  logic [Q_CNT_W-1:0] q_count;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      back_cfg.long_press_ms          <= LONG_PRESS_RST;
      back_cfg.double_press_window_ms <= DOUBLE_WINDOW_RST;
      back_cfg.change_threshold       <= CHANGE_THR_RST;
      invert_y                        <= INVERT_Y_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LONG_PRESS:    back_cfg.long_press_ms          <= cfg.data[MS_W-1:0];
        REG_DOUBLE_WINDOW: back_cfg.double_press_window_ms <= cfg.data[MS_W-1:0];
        REG_CHANGE_THR:    back_cfg.change_threshold       <= cfg.data[THR_W-1:0];
        REG_INVERT_Y:      invert_y                        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  jgef_front #(.ADC_CENTER(ADC_CENTER), .DEADZONE(DEADZONE)) u_front (
    .clk       (clk),
    .rst       (rst),
    .samp      (samp),
    .invert_y  (invert_y),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  jgef_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  jgef_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (back_cfg),
    .q_valid (q_count != '0),
    .head    (head),
    .pop     (pop),
    .evt     (evt)
  );

  // credit scheme never overfills the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> q_count < Q_CNT_W'(Q_DEPTH))
    else $error("item queue overflow");

  // scaled axes stay within range
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    evt.valid |-> (evt.x_pos <= 8'sd100) && (evt.x_pos >= -8'sd100) &&
                  (evt.y_pos <= 8'sd100) && (evt.y_pos >= -8'sd100))
    else $error("axis value out of range");

  // back-to-back events carry consecutive sequence numbers
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    evt.valid && evt.ready |=>
      !evt.valid || (evt.sequence_res == SEQ_W'($past(evt.sequence_res) + 1'b1)))
    else $error("event sequence skipped");

endmodule

### bench/jgef_event_checker.sv
// jgef_event_checker: watches the sample, event and configuration channels of
// the joystick gesture event filter, predicts each event and compares it
// depends on jgef_pkg and jgef_if
module jgef_event_checker import jgef_pkg::*; #(
  parameter int ADC_CENTER = 2048,
  parameter int DEADZONE   = 164
) (
  input  logic clk,
  input  logic rst,
  jgef_in_if   samp,
  jgef_out_if  evt,
  jgef_cfg_if  cfg,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [FLAG_W-1:0]       button_flags;
    logic [SEQ_W-1:0]        sequence_res;
  } event_t;

  event_t expected_events[$];

  // register copies
  logic [MS_W-1:0]  long_press_ms;
  logic [MS_W-1:0]  double_window_ms;
  logic [THR_W-1:0] change_thr;
  logic             invert_y;

  // gesture and change-detection state
  logic                    was_pressed;
  logic [TIME_W-1:0]       press_start;
  logic [TIME_W-1:0]       last_press_start;
  logic                    long_fired;
  logic [TALLY_W-1:0]      tally;
  logic signed [POS_W-1:0] sent_x;
  logic signed [POS_W-1:0] sent_y;
  logic [FLAG_W-1:0]       sent_flags;
  logic [SEQ_W-1:0]        event_seq;

  // centre, strip the deadzone, scale by truncating division, clamp and invert
  function automatic logic signed [POS_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
                                                       input logic inv);
    int c;
    int mag;
    int span;
    int n;
    c    = int'(raw) - ADC_CENTER;
    mag  = (c < 0) ? -c : c;
    span = ADC_CENTER - DEADZONE;
    if (mag < DEADZONE) return '0;
    c = (c > 0) ? c - DEADZONE : c + DEADZONE;
    if (span <= 0) begin
      n = (c > 0) ? SCALE_MAX : ((c < 0) ? -SCALE_MAX : 0);
    end else begin
      n = (c * SCALE_MAX) / span;
    end
    if (n > SCALE_MAX) n = SCALE_MAX;
    if (n < -SCALE_MAX) n = -SCALE_MAX;
    if (inv) n = -n;
    return n[POS_W-1:0];
  endfunction

  function automatic int axis_gap(input logic signed [POS_W-1:0] a,
                                  input logic signed [POS_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  always @(posedge clk) begin : track
    logic signed [POS_W-1:0] nx;
    logic signed [POS_W-1:0] ny;
    logic [FLAG_W-1:0]       flags;
    logic [TIME_W-1:0]       gap;
    logic                    stick;
    event_t                  want;
    if (rst) begin
      long_press_ms    = LONG_PRESS_RST;
      double_window_ms = DOUBLE_WINDOW_RST;
      change_thr       = CHANGE_THR_RST;
      invert_y         = INVERT_Y_RST;
      was_pressed      = 1'b0;
      press_start      = '0;
      last_press_start = '0;
      long_fired       = 1'b0;
      tally            = '0;
      sent_x           = '0;
      sent_y           = '0;
      sent_flags       = '0;
      event_seq        = '0;
      expected_events.delete();
    end else begin
      // register writes; unknown indexes are dropped, high bits masked
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LONG_PRESS:    long_press_ms    = cfg.data[MS_W-1:0];
          REG_DOUBLE_WINDOW: double_window_ms = cfg.data[MS_W-1:0];
          REG_CHANGE_THR:    change_thr       = cfg.data[THR_W-1:0];
          REG_INVERT_Y:      invert_y         = cfg.data[0];
          default: ;
        endcase
      end

      // predict the event caused by an accepted sample item
      if (samp.valid && samp.ready) begin
        stick = samp.stick_pressed;
        nx    = scale_axis(samp.raw_x, 1'b0);
        ny    = scale_axis(samp.raw_y, invert_y);
        flags = '0;
        if (stick && !was_pressed) begin
          press_start = samp.now_ms;
          long_fired  = 1'b0;
          gap         = samp.now_ms - last_press_start;
          if (gap < double_window_ms) begin
            if (tally != TALLY_MAX) tally = tally + 1'b1;
          end else begin
            tally = TALLY_FIRST;
          end
          last_press_start = samp.now_ms;
        end
        if (stick) begin
          flags[FLAG_PRESS] = 1'b1;
          gap = samp.now_ms - press_start;
          if (!long_fired && gap > long_press_ms) begin
            flags[FLAG_LONG] = 1'b1;
            long_fired       = 1'b1;
          end
        end
        if (!stick && was_pressed && tally >= DOUBLE_MIN_TALLY) flags[FLAG_DOUBLE] = 1'b1;
        was_pressed      = stick;
        flags[FLAG_HOME] = samp.home_btn;
        flags[FLAG_BACK] = samp.back_btn;
        if (axis_gap(nx, sent_x) > int'(change_thr) || axis_gap(ny, sent_y) > int'(change_thr)
            || flags != sent_flags) begin
          event_seq  = event_seq + 1'b1;
          sent_x     = nx;
          sent_y     = ny;
          sent_flags = flags;
          want.x_pos        = nx;
          want.y_pos        = ny;
          want.button_flags = flags;
          want.sequence_res = event_seq;
          expected_events.push_back(want);
        end
      end

      // compare an accepted event item with the oldest prediction
      if (evt.valid && evt.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event item, sequence_res %0d", evt.sequence_res);
          fails++;
        end else begin
          want = expected_events.pop_front();
          if (evt.x_pos !== want.x_pos) begin
            $error("x_pos: expected %0d, got %0d", want.x_pos, evt.x_pos);
            fails++;
          end
          if (evt.y_pos !== want.y_pos) begin
            $error("y_pos: expected %0d, got %0d", want.y_pos, evt.y_pos);
            fails++;
          end
          if (evt.button_flags !== want.button_flags) begin
            $error("button_flags: expected %b, got %b", want.button_flags, evt.button_flags);
            fails++;
          end
          if (evt.sequence_res !== want.sequence_res) begin
            $error("sequence_res: expected %0d, got %0d", want.sequence_res, evt.sequence_res);
            fails++;
          end
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

### bench/joystick_gesture_event_filter_tb.sv
// joystick_gesture_event_filter_tb: drives samples, settings and event back
// pressure into the filter and gives the verdict from jgef_event_checker
// depends on jgef_pkg, jgef_if, jgef_event_checker and the filter itself
module joystick_gesture_event_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jgef_pkg::*;

  localparam int ADC_CENTER     = 2048;
  localparam int DEADZONE       = 164;
  localparam int RAW_MAX        = (1 << RAW_W) - 1;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_ITEMS    = 30;
  localparam int PHASES         = 6;
  localparam int BURST_PRESSES  = 257;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(REG_INVERT_Y + 1);
  localparam logic [CFG_IDX_W-1:0] REG_FAR  = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   idle_cycles = 0;
  int   items_sent = 0;

  // current stimulus state
  logic [TIME_W-1:0] clock_ms;
  logic [RAW_W-1:0]  cur_x;
  logic [RAW_W-1:0]  cur_y;
  logic              cur_stick;
  logic              cur_home;
  logic              cur_back;
  int                long_cfg;
  int                window_cfg;
  int                thr_cfg;

  jgef_in_if  samp_if ();
  jgef_out_if evt_if ();
  jgef_cfg_if cfg_if ();

  joystick_gesture_event_filter #(
    .ADC_CENTER (ADC_CENTER),
    .DEADZONE   (DEADZONE)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .samp (samp_if),
    .evt  (evt_if),
    .cfg  (cfg_if)
  );

  jgef_event_checker #(
    .ADC_CENTER (ADC_CENTER),
    .DEADZONE   (DEADZONE)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .samp    (samp_if),
    .evt     (evt_if),
    .cfg     (cfg_if),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // event back pressure
  always @(negedge clk) begin
    evt_if.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((samp_if.valid && samp_if.ready) || (evt_if.valid && evt_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one sample item, with random sender gaps ahead of it
  task automatic push_sample(input int x, input int y,
                             input logic stick, input logic home, input logic back,
                             input int unsigned step);
    while ($urandom_range(99) < send_idle_pct) begin
      samp_if.valid = 1'b0;
      @(negedge clk);
    end
    clock_ms  = clock_ms + step;
    cur_x     = x[RAW_W-1:0];
    cur_y     = y[RAW_W-1:0];
    cur_stick = stick;
    cur_home  = home;
    cur_back  = back;
    samp_if.valid         = 1'b1;
    samp_if.raw_x         = x[RAW_W-1:0];
    samp_if.raw_y         = y[RAW_W-1:0];
    samp_if.stick_pressed = stick;
    samp_if.home_btn      = home;
    samp_if.back_btn      = back;
    samp_if.now_ms        = clock_ms;
    do @(posedge clk); while (!samp_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // wait until every event is out and the pipeline is empty
  task automatic settle();
    samp_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // all four registers, with junk above the narrow fields and a stray index
  task automatic apply_settings(input int lp, input int win, input int thr, input logic inv);
    logic [31:0] junk;
    junk = $urandom();
    settle();
    cfg_write(REG_LONG_PRESS, lp[MS_W-1:0]);
    cfg_write(REG_DOUBLE_WINDOW, win[MS_W-1:0]);
    cfg_write(REG_CHANGE_THR, {junk[7:0], thr[THR_W-1:0]});
    cfg_write(REG_INVERT_Y, {junk[22:8], inv});
    cfg_write(($urandom_range(1) != 0) ? REG_NONE : REG_FAR, junk[31:16]);
    long_cfg   = lp;
    window_cfg = win;
    thr_cfg    = thr;
  endtask

  // axis value: held, extreme, deadzone edge, nudge or anything
  function automatic int next_raw(input logic [RAW_W-1:0] cur);
    int v;
    int span;
    v = int'(cur);
    case ($urandom_range(9))
      0, 1, 2: ;
      3: v = 0;
      4: v = RAW_MAX;
      5: begin
        span = DEADZONE + int'($urandom_range(2)) - 1;
        v = ($urandom_range(1) != 0) ? ADC_CENTER + span : ADC_CENTER - span;
      end
      6, 7: begin
        span = thr_cfg * 19 + 60;
        v = v + int'($urandom_range(2 * span)) - span;
      end
      default: v = $urandom_range(RAW_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v;
  endfunction

  function automatic logic flip(input logic cur);
    return cur ^ ($urandom_range(4) == 0);
  endfunction

  function automatic int unsigned noise_step();
    case ($urandom_range(9))
      0:       return $urandom();
      1, 2:    return $urandom_range(2000);
      default: return $urandom_range(30);
    endcase
  endfunction

  // one random gesture: noise, tap, multi-tap around the window, long hold or sweep
  task automatic run_gesture();
    int gap;
    int a;
    int b;
    case ($urandom_range(4))
      0: repeat ($urandom_range(1, 4))
           push_sample(next_raw(cur_x), next_raw(cur_y), 1'($urandom_range(1)),
                       flip(cur_home), flip(cur_back), noise_step());
      1: begin
        push_sample(next_raw(cur_x), next_raw(cur_y), 1'b1, flip(cur_home), flip(cur_back),
                    $urandom_range(1, 50));
        repeat ($urandom_range(2))
          push_sample(next_raw(cur_x), next_raw(cur_y), 1'b1, flip(cur_home),
                      flip(cur_back), $urandom_range(1, 50));
        push_sample(next_raw(cur_x), next_raw(cur_y), 1'b0, flip(cur_home), flip(cur_back),
                    $urandom_range(1, 50));
      end
      2: begin
        push_sample(next_raw(cur_x), next_raw(cur_y), 1'b0, cur_home, cur_back,
                    $urandom_range(1, 20));
        b = $urandom_range(1, 20);
        repeat ($urandom_range(2, 5)) begin
          push_sample(next_raw(cur_x), next_raw(cur_y), 1'b1, flip(cur_home),
                      flip(cur_back), b);
          gap = window_cfg + int'($urandom_range(3)) - 2;
          if (gap < 0) gap = 0;
          a = $urandom_range(gap);
          push_sample(next_raw(cur_x), next_raw(cur_y), 1'b0, flip(cur_home),
                      flip(cur_back), a);
          b = gap - a;
        end
      end
      3: begin
        push_sample(next_raw(cur_x), next_raw(cur_y), 1'b1, cur_home, cur_back,
                    $urandom_range(1, 20));
        gap = long_cfg + int'($urandom_range(3)) - 1;
        if (gap < 0) gap = 0;
        push_sample(next_raw(cur_x), next_raw(cur_y), 1'b1, cur_home, cur_back, gap);
        repeat ($urandom_range(1, 3))
          push_sample(next_raw(cur_x), next_raw(cur_y), 1'b1, flip(cur_home),
                      flip(cur_back), $urandom_range(1, 500));
        push_sample(next_raw(cur_x), next_raw(cur_y), 1'b0, cur_home, cur_back,
                    $urandom_range(1, 20));
      end
      default: repeat ($urandom_range(2, 6))
        push_sample(next_raw(cur_x), next_raw(cur_y), cur_stick, cur_home, cur_back,
                    $urandom_range(30));
    endcase
  endtask

  initial begin
    int phase_base;
    samp_if.valid         = 1'b0;
    samp_if.raw_x         = '0;
    samp_if.raw_y         = '0;
    samp_if.stick_pressed = 1'b0;
    samp_if.home_btn      = 1'b0;
    samp_if.back_btn      = 1'b0;
    samp_if.now_ms        = '0;
    evt_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    send_idle_pct = 29;
    recv_idle_pct = 57;
    long_cfg   = int'(LONG_PRESS_RST);
    window_cfg = int'(DOUBLE_WINDOW_RST);
    thr_cfg    = int'(CHANGE_THR_RST);
    clock_ms   = $urandom();
    cur_x      = RAW_W'(ADC_CENTER);
    cur_y      = RAW_W'(ADC_CENTER);
    cur_stick  = 1'b0;
    cur_home   = 1'b0;
    cur_back   = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: axis extremes and deadzone edges at reset settings
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 5);
    push_sample(0, RAW_MAX, 1'b0, 1'b0, 1'b0, 5);
    push_sample(RAW_MAX, 0, 1'b0, 1'b0, 1'b0, 5);
    push_sample(ADC_CENTER + DEADZONE - 1, ADC_CENTER - DEADZONE + 1, 1'b0, 1'b0, 1'b0, 5);
    push_sample(ADC_CENTER + DEADZONE, ADC_CENTER - DEADZONE, 1'b0, 1'b0, 1'b0, 5);
    push_sample(ADC_CENTER + DEADZONE + 1, ADC_CENTER - DEADZONE - 1, 1'b0, 1'b0, 1'b0, 5);
    // home and back levels
    push_sample(ADC_CENTER - DEADZONE - 100, ADC_CENTER + DEADZONE + 100, 1'b0, 1'b1, 1'b0, 5);
    push_sample(ADC_CENTER - DEADZONE - 100, ADC_CENTER + DEADZONE + 100, 1'b0, 1'b1, 1'b1, 5);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 5);
    // single press, then a second one inside the window gives the double flag
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 10);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 50);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 50);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 20);
    // long press: held exactly the limit, one past it, then no repeat
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 1000);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 700);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 1);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 200);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 10);
    // long press held across the timestamp wrap
    clock_ms = 32'hFFFF_FF80;
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 0);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 800);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 5);
    // second press exactly one window later is not consecutive
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 5);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 150);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b1, 1'b0, 1'b0, 150);
    push_sample(ADC_CENTER, ADC_CENTER, 1'b0, 1'b0, 1'b0, 1);

    // random phases, each with its own settings and idling
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: apply_settings(0, 0, 0, 1'b0);
        1: apply_settings((1 << MS_W) - 1, (1 << MS_W) - 1, 200, 1'b1);
        2: apply_settings($urandom_range(3000), $urandom_range(1000), (1 << THR_W) - 1,
                          1'($urandom_range(1)));
        3: apply_settings($urandom_range(2000), $urandom_range(600), $urandom_range(12),
                          1'($urandom_range(1)));
        4: apply_settings(int'(LONG_PRESS_RST), int'(DOUBLE_WINDOW_RST),
                          int'(CHANGE_THR_RST), INVERT_Y_RST);
        default: apply_settings($urandom_range((1 << MS_W) - 1),
                                $urandom_range((1 << MS_W) - 1),
                                $urandom_range((1 << THR_W) - 1), 1'($urandom_range(1)));
      endcase
      phase_base = items_sent;
      // press burst long enough to drive the tally into saturation
      if (phase == 1) begin
        push_sample(next_raw(cur_x), next_raw(cur_y), 1'b0, cur_home, cur_back, 10);
        repeat (BURST_PRESSES) begin
          push_sample(next_raw(cur_x), next_raw(cur_y), 1'b1, flip(cur_home),
                      flip(cur_back), $urandom_range(1, 3));
          push_sample(next_raw(cur_x), next_raw(cur_y), 1'b0, flip(cur_home),
                      flip(cur_back), $urandom_range(1, 3));
        end
      end
      while (items_sent - phase_base < PHASE_ITEMS) run_gesture();
    end

    // drain and verdict
    settle();
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
